// ===== hw/rtl/i2cmbe_pkg.sv =====
// ============================================================================
// I2C master byte engine package
// Shared types and constants of the byte engine: command codes, the engine's
// one-hot command state, and the packed item, result and status structures.
// ============================================================================
package i2cmbe_pkg;

    localparam int DELAY_W = 16;
    localparam int BYTE_W = 8;
    localparam int MODE_W = 3;
    localparam int BIT_W = 4;
    localparam int PHASE_W = 2;
    localparam int IN_DATA_W = 16;
    localparam int OUT_DATA_W = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd150;
    localparam logic [BIT_W-1:0] BITS_PER_BYTE = 4'd8;

    localparam logic [MODE_W-1:0] MODE_START = 3'd1;
    localparam logic [MODE_W-1:0] MODE_STOP = 3'd2;
    localparam logic [MODE_W-1:0] MODE_WRITE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ = 3'd4;

    localparam logic [PHASE_W-1:0] PHASE_0 = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_1 = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_2 = 2'd2;

    typedef enum logic [4:0] {
        CMD_IDLE = 5'b00001,
        CMD_START = 5'b00010,
        CMD_STOP = 5'b00100,
        CMD_WRITE = 5'b01000,
        CMD_READ = 5'b10000
    } t_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [BYTE_W-1:0] data_byte;
        logic ack_to_send;
        logic sda_in;
    } t_item;

    typedef struct packed {
        logic ack_seen;
        logic [BYTE_W-1:0] read_data;
        logic done_res;
        logic busy_res;
        logic sda_out;
        logic scl_out;
    } t_result;

    typedef struct packed {
        logic busy;
        logic delay_zero;
    } t_seq_status;

endpackage

// ===== hw/rtl/i2c_master_byte_engine_core.sv =====
// ============================================================================
// I2C master byte engine
// One input transfer is one timing tick; each tick yields one result transfer
// with the SCL and SDA drive levels and the command status.
// ============================================================================
// Input channel: s_tuser carries the mode (0 tick only, 1 start, 2 stop,
// 3 write byte, 4 read byte); s_tdata carries data_byte, ack_to_send and the
// sampled SDA level. A command is taken only while the engine is idle.
// Output channel: one result per input transfer, in order, with scl_out,
// sda_out, busy_res, done_res, read_data and ack_seen.
// The APB register at address 0 holds delay_ticks, the ticks between pin
// changes; write it only while the engine is idle.
// A result passes from the input register through the tick logic to the output
// register before it is valid. One transfer is taken per cycle while the
// receiver does not stall: the input register feeds the tick logic, whose
// outcome is registered in the output register.
// When the receiver stalls, the result is held and the input register still
// fills, after which s_tready drops until the result is taken.
// Reset clears the valid flags and the sequencer state, releases both lines
// high and sets delay_ticks to 150.
// ============================================================================
module i2c_master_byte_engine_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // [7:0] data_byte, [8] ack_to_send, [9] sda_in, [15:10] zero
    input  logic [i2cmbe_pkg::IN_DATA_W-1:0]       i_s_tdata,
    // [2:0] mode
    input  logic [i2cmbe_pkg::MODE_W-1:0]          i_s_tuser,
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res,
    // [11:4] read_data, [12] ack_seen, [15:13] zero
    output logic [i2cmbe_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [i2cmbe_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [i2cmbe_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [i2cmbe_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                   pready
);
    import i2cmbe_pkg::*;

    logic                r_in_valid;
    t_item               r_in_item;
    logic                r_out_valid;
    t_result             r_out;
    logic [DELAY_W-1:0]  r_delay;
    logic                advance;
    logic                reg_sel;
    t_result             seq_result;
    t_seq_status         seq_status;

    assign advance = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || advance;
    assign reg_sel = (paddr[APB_ADDR_W-1] == 1'b0);

    i2cmbe_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (r_in_valid && advance),
        .i_item        (r_in_item),
        .i_delay_ticks (r_delay),
        .o_result      (seq_result),
        .o_status      (seq_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_item.mode <= i_s_tuser;
            r_in_item.data_byte <= i_s_tdata[BYTE_W-1:0];
            r_in_item.ack_to_send <= i_s_tdata[BYTE_W];
            r_in_item.sda_in <= i_s_tdata[BYTE_W+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out <= seq_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= DELAY_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_delay <= pwdata[DELAY_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = reg_sel ? {{(APB_DATA_W-DELAY_W){1'b0}}, r_delay} : '0;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata = {{(OUT_DATA_W-$bits(t_result)){1'b0}}, r_out};

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> !r_out.busy_res)
        else $error("done result reports busy");

    a_idle_no_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !seq_status.busy |-> seq_status.delay_zero)
        else $error("idle engine holds a pending delay");

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_item)))
        else $error("stalled input item lost");

endmodule

// ===== hw/rtl/i2cmbe_seq.sv =====
// ============================================================================
// I2C master byte engine sequencer
// Holds the command state and advances it by one tick for each processed
// item, producing the pin levels and status of that tick.
// ============================================================================
module i2cmbe_seq (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  i2cmbe_pkg::t_item                      i_item,
    input  logic [i2cmbe_pkg::DELAY_W-1:0]         i_delay_ticks,
    output i2cmbe_pkg::t_result                    o_result,
    output i2cmbe_pkg::t_seq_status                o_status
);
    import i2cmbe_pkg::*;

    t_cmd                r_cmd, n_cmd;
    logic [PHASE_W-1:0]  r_phase, n_phase;
    logic [BIT_W-1:0]    r_bit, n_bit;
    logic [BYTE_W-1:0]   r_shift, n_shift;
    logic [DELAY_W-1:0]  r_dc, n_dc;
    logic                r_scl, n_scl;
    logic                r_sda, n_sda;
    logic                r_ack, n_ack;
    logic [BYTE_W-1:0]   r_read, n_read;
    logic                r_hold, n_hold;
    logic                done;
    logic [DELAY_W-1:0]  eff_delay;
    logic [DELAY_W-1:0]  dc_dec;
    logic [BIT_W-1:0]    bit_next;
    logic [BYTE_W-1:0]   shifted;

    assign eff_delay = (i_delay_ticks == '0) ? {{(DELAY_W-1){1'b0}}, 1'b1} : i_delay_ticks;
    assign dc_dec = (r_dc != '0) ? r_dc - {{(DELAY_W-1){1'b0}}, 1'b1} : r_dc;
    assign bit_next = r_bit + {{(BIT_W-1){1'b0}}, 1'b1};
    assign shifted = (r_cmd == CMD_WRITE) ? {r_shift[BYTE_W-2:0], 1'b0}
                                          : {r_shift[BYTE_W-2:0], i_item.sda_in};

    always_comb begin
        n_cmd = r_cmd;
        n_phase = r_phase;
        n_bit = r_bit;
        n_shift = r_shift;
        n_dc = r_dc;
        n_scl = r_scl;
        n_sda = r_sda;
        n_ack = r_ack;
        n_read = r_read;
        n_hold = r_hold;
        done = 1'b0;
        unique case (r_cmd) inside
            CMD_IDLE: begin
                case (i_item.mode)
                    MODE_START: begin
                        n_cmd = CMD_START;
                        n_phase = PHASE_0;
                        n_sda = 1'b1;
                        n_scl = 1'b1;
                        n_dc = eff_delay;
                    end
                    MODE_STOP: begin
                        n_cmd = CMD_STOP;
                        n_phase = PHASE_0;
                        n_sda = 1'b0;
                        n_dc = eff_delay;
                    end
                    MODE_WRITE: begin
                        n_cmd = CMD_WRITE;
                        n_bit = '0;
                        n_shift = i_item.data_byte;
                        n_sda = i_item.data_byte[BYTE_W-1];
                        n_phase = PHASE_0;
                        n_dc = eff_delay;
                    end
                    MODE_READ: begin
                        n_cmd = CMD_READ;
                        n_bit = '0;
                        n_shift = '0;
                        n_hold = i_item.ack_to_send;
                        n_sda = 1'b1;
                        n_phase = PHASE_0;
                        n_dc = eff_delay;
                    end
                    default: begin
                    end
                endcase
            end
            CMD_START: begin
                n_dc = dc_dec;
                if (dc_dec == '0) begin
                    if (r_phase == PHASE_0) begin
                        n_sda = 1'b0;
                        n_phase = PHASE_1;
                        n_dc = eff_delay;
                    end else begin
                        n_scl = 1'b0;
                        n_cmd = CMD_IDLE;
                        n_phase = PHASE_0;
                        n_bit = '0;
                        n_dc = '0;
                        done = 1'b1;
                    end
                end
            end
            CMD_STOP: begin
                n_dc = dc_dec;
                if (dc_dec == '0) begin
                    if (r_phase == PHASE_0) begin
                        n_scl = 1'b1;
                        n_phase = PHASE_1;
                        n_dc = eff_delay;
                    end else if (r_phase == PHASE_1) begin
                        n_sda = 1'b1;
                        n_phase = PHASE_2;
                        n_dc = eff_delay;
                    end else begin
                        n_cmd = CMD_IDLE;
                        n_phase = PHASE_0;
                        n_bit = '0;
                        n_dc = '0;
                        done = 1'b1;
                    end
                end
            end
            CMD_WRITE, CMD_READ: begin
                n_dc = dc_dec;
                if (dc_dec == '0) begin
                    if (r_phase == PHASE_0) begin
                        n_scl = 1'b1;
                        n_phase = PHASE_1;
                        n_dc = eff_delay;
                    end else begin
                        n_scl = 1'b0;
                        if (r_bit < BITS_PER_BYTE) begin
                            n_shift = shifted;
                        end else if (r_cmd == CMD_WRITE) begin
                            n_ack = i_item.sda_in;
                        end
                        n_bit = bit_next;
                        if (bit_next > BITS_PER_BYTE) begin
                            if (r_cmd == CMD_READ) begin
                                n_read = r_shift;
                            end
                            n_cmd = CMD_IDLE;
                            n_phase = PHASE_0;
                            n_bit = '0;
                            n_dc = '0;
                            done = 1'b1;
                        end else begin
                            n_phase = PHASE_0;
                            n_dc = eff_delay;
                            if (r_cmd == CMD_WRITE) begin
                                n_sda = (bit_next < BITS_PER_BYTE) ? shifted[BYTE_W-1] : 1'b1;
                            end else begin
                                n_sda = (bit_next >= BITS_PER_BYTE) ? r_hold : 1'b1;
                            end
                        end
                    end
                end
            end
            default: begin
                n_cmd = CMD_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd <= CMD_IDLE;
            r_phase <= '0;
            r_bit <= '0;
            r_shift <= '0;
            r_dc <= '0;
            r_scl <= 1'b1;
            r_sda <= 1'b1;
            r_ack <= 1'b0;
            r_read <= '0;
            r_hold <= 1'b0;
        end else if (i_en) begin
            r_cmd <= n_cmd;
            r_phase <= n_phase;
            r_bit <= n_bit;
            r_shift <= n_shift;
            r_dc <= n_dc;
            r_scl <= n_scl;
            r_sda <= n_sda;
            r_ack <= n_ack;
            r_read <= n_read;
            r_hold <= n_hold;
        end
    end

    assign o_result.scl_out = n_scl;
    assign o_result.sda_out = n_sda;
    assign o_result.busy_res = (n_cmd != CMD_IDLE);
    assign o_result.done_res = done;
    assign o_result.read_data = n_read;
    assign o_result.ack_seen = n_ack;

    assign o_status.busy = (r_cmd != CMD_IDLE);
    assign o_status.delay_zero = (r_dc == '0);

endmodule
